// File: src/nafr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and byte-sequence helpers for the Annex B framer.
// No dependencies.
package nafr_pkg;

  localparam logic [7:0] NAL_TYPE_MASK = 8'h1f;
  localparam logic [4:0] NAL_TYPE_SPS  = 5'd7;
  localparam logic [4:0] NAL_TYPE_PPS  = 5'd8;
  localparam logic [7:0] ESCAPE_BYTE   = 8'h03;
  localparam logic [7:0] ESCAPE_LIMIT  = 8'h03;
  localparam logic [1:0] RUN_SAT       = 2'd2;

  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_ESCAPE,
    KIND_START3,
    KIND_START4
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [2:0] cmd_count(input kind_t kind);
    logic [2:0] n;
    unique case (kind)
      KIND_PLAIN:  n = 3'd1;
      KIND_ESCAPE: n = 3'd2;
      KIND_START3: n = 3'd4;
      KIND_START4: n = 3'd5;
      default:     n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] cmd_byte(input kind_t kind, input logic [7:0] data,
                                          input logic [2:0] idx);
    logic [7:0] b;
    unique case (kind)
      KIND_PLAIN:  b = data;
      KIND_ESCAPE: b = (idx == 3'd0) ? ESCAPE_BYTE : data;
      KIND_START3: b = (idx < 3'd2) ? 8'h00 : ((idx == 3'd2) ? 8'h01 : data);
      KIND_START4: b = (idx < 3'd3) ? 8'h00 : ((idx == 3'd3) ? 8'h01 : data);
      default:     b = data;
    endcase
    return b;
  endfunction

endpackage

// File: src/nal_annexb_framer_with_escape_unit.sv
`timescale 1ns / 1ps
// Annex B framer with emulation prevention: classifier, command queue, byte emitter.
// The first output byte of an input passes through the command queue and the output register.
// Throughput: one input per cycle for plain payload while the queue is not full; an item
// gives 1 (plain), 2 (escape), 4 or 5 (start code + header) output bytes, each held by m_tready.
// Reset: rst synchronous active high; clears zero run, queue and output valid.
// Depends on nafr_pkg, nafr_front, nafr_queue, nafr_back.
module nal_annexb_framer_with_escape_unit
  import nafr_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // data_byte
  input  logic [1:0] s_tuser,   // [0] nal_begin, [1] picture_begin
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte
  output logic       m_tlast    // run_last
);

  q_stat_t q_stat;
  logic    push;
  cmd_t    push_cmd;
  logic    pop;
  cmd_t    head;

  nafr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  nafr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  nafr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    push |=> !q_stat.empty)
    else $error("queue empty after push");

  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue both full and empty");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule

// File: src/nafr_front.sv
`timescale 1ns / 1ps
// Input side: accepts NAL bytes, tracks the zero run and classifies each byte.
// Depends on nafr_pkg.
module nafr_front
  import nafr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // data_byte
  input  logic [1:0] s_tuser,   // [0] nal_begin, [1] picture_begin
  input  q_stat_t    q_stat,
  output logic       push,
  output cmd_t       push_cmd
);

  logic [1:0] zero_run;
  logic [1:0] zero_run_next;
  logic [4:0] nal_type;
  logic       esc;

  assign s_tready = !q_stat.full;
  assign push     = s_tvalid && s_tready;
  assign nal_type = 5'(s_tdata & NAL_TYPE_MASK);
  assign esc      = (zero_run >= RUN_SAT) && (s_tdata <= ESCAPE_LIMIT);

  always_comb begin
    push_cmd.data = s_tdata;
    zero_run_next = zero_run;
    if (s_tuser[0]) begin
      if (s_tuser[1] || nal_type == NAL_TYPE_SPS || nal_type == NAL_TYPE_PPS) begin
        push_cmd.kind = KIND_START4;
      end else begin
        push_cmd.kind = KIND_START3;
      end
      zero_run_next = 2'd0;
    end else begin
      push_cmd.kind = esc ? KIND_ESCAPE : KIND_PLAIN;
      if (s_tdata == 8'h00) begin
        if (esc) begin
          zero_run_next = 2'd1;
        end else if (zero_run < RUN_SAT) begin
          zero_run_next = zero_run + 2'd1;
        end
      end else begin
        zero_run_next = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run <= 2'd0;
    end else if (push) begin
      zero_run <= zero_run_next;
    end
  end

endmodule

// File: src/nafr_queue.sv
`timescale 1ns / 1ps
// Command queue between the classifier and the byte emitter.
// Depends on nafr_pkg.
module nafr_queue
  import nafr_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head         = mem[rd_ptr];
  assign q_stat.full  = (count == FULL_CNT);
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: src/nafr_back.sv
`timescale 1ns / 1ps
// Output side: expands queued commands into start codes, escapes and data bytes.
// Depends on nafr_pkg.
module nafr_back
  import nafr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  q_stat_t    q_stat,
  input  cmd_t       head,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte
  output logic       m_tlast    // run_last
);

  cmd_t       cur;
  logic [2:0] step;
  logic       busy;
  logic       adv;
  logic       have;
  cmd_t       src;
  logic [2:0] idx;
  logic       at_end;

  assign adv    = !m_tvalid || m_tready;
  assign have   = busy || !q_stat.empty;
  assign src    = busy ? cur : head;
  assign idx    = busy ? step : 3'd0;
  assign at_end = (idx == cmd_count(src.kind) - 3'd1);
  assign pop    = adv && !busy && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      step     <= 3'd0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= have;
      if (have) begin
        m_tdata <= cmd_byte(src.kind, src.data, idx);
        m_tlast <= at_end;
        if (at_end) begin
          busy <= 1'b0;
        end else begin
          busy <= 1'b1;
          step <= idx + 3'd1;
        end
        if (!busy) begin
          cur <= head;
        end
      end
    end
  end

endmodule
